[hw/rtl/igmpcc_pkg.sv]
// ----------------------------------------------------------------------------
// IGMP checksum checker package
// Shared types, codes and the ones' complement adder for the checker block.
// ----------------------------------------------------------------------------
package igmpcc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned FCNT_W = 4;

    localparam logic [1:0] VERDICT_PASS  = 2'd0;
    localparam logic [1:0] VERDICT_BAD   = 2'd1;
    localparam logic [1:0] VERDICT_TRUNC = 2'd2;

    localparam logic CFG_MSG_TYPE      = 1'b0;
    localparam logic CFG_HEADER_OFFSET = 1'b1;

    localparam logic MSG_QUERY = 1'b0;

    typedef enum logic [2:0] {
        PH_SKIP    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_RECORD  = 3'd2,
        PH_SOURCES = 3'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        verdict;
        logic [WORD_W-1:0] computed_sum;
        logic [WORD_W-1:0] received_sum;
    } t_out_item;

    function automatic logic [WORD_W-1:0] ones_add(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b
    );
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

[hw/rtl/igmp_checksum_checker.sv]
// ----------------------------------------------------------------------------
// IGMP checksum checker
// Parses an IGMPv3 message out of a byte stream and checks its checksum.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle and, on the byte marked last,
// returns one transaction with the verdict (pass, bad checksum or truncated),
// the checksum it computed and the checksum field it received. A byte is
// registered at the input, then the parse state and the running 16-bit ones'
// complement sum are updated from that register, so the sustained rate is one
// byte per clock; a result is registered at the output as its last byte
// leaves the input register. Bytes that cause no result never wait for the
// output side; a last byte waits only while the previous result is still held.
module igmp_checksum_checker
    import igmpcc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item
);

    logic              r_msg_type;
    logic [BYTE_W-1:0] r_header_offset;

    logic     r_s1_valid;
    t_in_item r_s1_item;

    t_phase            r_phase, n_phase;
    logic [WORD_W-1:0] r_pos, n_pos;
    logic [WORD_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_held, n_held;
    logic [WORD_W-1:0] r_chk, n_chk;
    logic [WORD_W-1:0] r_rec, n_rec;
    logic [WORD_W-1:0] r_src, n_src;
    logic [FCNT_W-1:0] r_fcnt, n_fcnt;
    logic              r_complete, n_complete;

    logic      r_out_valid;
    t_out_item r_out_item, n_out_item;

    logic out_free;
    logic advance;
    logic in_accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && (!r_s1_item.last_byte || out_free);
    assign o_in_stall = r_s1_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_type      <= MSG_QUERY;
            r_header_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MSG_TYPE:      r_msg_type      <= i_cfg_data[0];
                CFG_HEADER_OFFSET: r_header_offset <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_item;
        end
    end

    always_comb begin
        t_phase            ph;
        logic [WORD_W-1:0] pos;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] v;
        logic              odd;
        logic              low_next;
        logic [WORD_W-1:0] fin;

        b          = r_s1_item.data_byte;
        ph         = r_phase;
        pos        = r_pos;
        v          = b;
        odd        = 1'b0;
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_held     = r_held;
        n_chk      = r_chk;
        n_rec      = r_rec;
        n_src      = r_src;
        n_fcnt     = r_fcnt;
        n_complete = r_complete;

        if (!r_complete) begin
            if (r_phase == PH_SKIP && r_pos < {{(WORD_W-BYTE_W){1'b0}}, r_header_offset}) begin
                n_pos = r_pos + 1'b1;
            end else begin
                if (r_phase == PH_SKIP) begin
                    ph  = PH_HEADER;
                    pos = '0;
                end
                n_phase = ph;
                odd     = (ph == PH_HEADER) ? pos[0] : r_fcnt[0];

                if (ph == PH_HEADER && pos == 16'd2) begin
                    n_chk[15:8] = b;
                    v           = '0;
                end else if (ph == PH_HEADER && pos == 16'd3) begin
                    n_chk[7:0] = b;
                    v          = '0;
                end

                if (odd) begin
                    n_sum = ones_add(r_sum, {r_held, v});
                end else begin
                    n_held = v;
                end

                case (ph)
                    PH_HEADER: begin
                        if (r_msg_type == MSG_QUERY) begin
                            if (pos >= 16'd11) begin
                                n_complete = 1'b1;
                            end
                        end else begin
                            if (pos == 16'd6) begin
                                n_rec[15:8] = b;
                            end else if (pos == 16'd7) begin
                                n_rec[7:0] = b;
                            end
                            if (pos >= 16'd7) begin
                                n_fcnt = '0;
                                if (n_rec == '0) begin
                                    n_complete = 1'b1;
                                end else begin
                                    n_phase = PH_RECORD;
                                end
                            end
                        end
                    end
                    PH_RECORD: begin
                        if (r_fcnt == 4'd2) begin
                            n_src[15:8] = b;
                        end else if (r_fcnt == 4'd3) begin
                            n_src[7:0] = b;
                        end
                        if (r_fcnt >= 4'd7) begin
                            n_fcnt = '0;
                            if (n_src == '0) begin
                                n_rec = r_rec - 1'b1;
                                if (n_rec == '0) begin
                                    n_complete = 1'b1;
                                end else begin
                                    n_phase = PH_RECORD;
                                end
                            end else begin
                                n_phase = PH_SOURCES;
                            end
                        end else begin
                            n_fcnt = r_fcnt + 1'b1;
                        end
                    end
                    default: begin
                        if (r_fcnt >= 4'd3) begin
                            n_fcnt = '0;
                            n_src  = r_src - 1'b1;
                            if (n_src == '0) begin
                                n_rec = r_rec - 1'b1;
                                if (n_rec == '0) begin
                                    n_complete = 1'b1;
                                end else begin
                                    n_phase = PH_RECORD;
                                end
                            end
                        end else begin
                            n_fcnt = r_fcnt + 1'b1;
                        end
                    end
                endcase

                n_pos = (pos != '1) ? pos + 1'b1 : pos;
            end
        end

        // A pending high byte is padded with a zero low byte.
        low_next = !n_complete && n_phase != PH_SKIP
                   && ((n_phase == PH_HEADER) ? n_pos[0] : n_fcnt[0]);
        fin      = low_next ? ones_add(n_sum, {n_held, {BYTE_W{1'b0}}}) : n_sum;
        fin      = ~fin;

        n_out_item.computed_sum = fin;
        n_out_item.received_sum = n_chk;
        if (!n_complete) begin
            n_out_item.verdict = VERDICT_TRUNC;
        end else if (fin == n_chk) begin
            n_out_item.verdict = VERDICT_PASS;
        end else begin
            n_out_item.verdict = VERDICT_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_s1_item.last_byte)) begin
            r_phase    <= PH_SKIP;
            r_pos      <= '0;
            r_sum      <= '0;
            r_held     <= '0;
            r_chk      <= '0;
            r_rec      <= '0;
            r_src      <= '0;
            r_fcnt     <= '0;
            r_complete <= 1'b0;
        end else if (advance) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_held     <= n_held;
            r_chk      <= n_chk;
            r_rec      <= n_rec;
            r_src      <= n_src;
            r_fcnt     <= n_fcnt;
            r_complete <= n_complete;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_s1_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_item.last_byte) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

[hw/rtl/igmpcc_checker.sv]
// ----------------------------------------------------------------------------
// IGMP checksum checker port checks
// Assertions on the ports of the checker block, attached by a bind.
// ----------------------------------------------------------------------------
module igmpcc_checker
    import igmpcc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output transaction present after reset.");

    a_stalled_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("Stalled output transaction changed.");

    a_pass_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.verdict == VERDICT_PASS
        |-> o_out_item.computed_sum == o_out_item.received_sum)
        else $error("Pass verdict with differing checksums.");

    a_bad_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.verdict == VERDICT_BAD
        |-> o_out_item.computed_sum != o_out_item.received_sum)
        else $error("Bad verdict with equal checksums.");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.verdict == VERDICT_PASS
            || o_out_item.verdict == VERDICT_BAD
            || o_out_item.verdict == VERDICT_TRUNC)
        else $error("Undefined verdict code.");

endmodule

bind igmp_checksum_checker igmpcc_checker u_igmpcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
